// ===== rtl/ray_circle_entry_point_assert.svh =====
// Assertion macros used by the checker of the ray-circle entry point block.
`ifndef RAY_CIRCLE_ENTRY_POINT_ASSERT_SVH
`define RAY_CIRCLE_ENTRY_POINT_ASSERT_SVH

// Same-cycle implication.
`define RCEP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rcep assertion failed");

// Next-cycle implication.
`define RCEP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rcep assertion failed");

`endif

// ===== rtl/rcep_pkg.sv =====
`timescale 1ns / 1ps
package rcep_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_MISS     = 2'd1;
    localparam status_t STATUS_ZERO_VEL = 2'd2;

    // digit width of the shift-add multipliers
    localparam int DIGIT_BITS = 16;

endpackage

// ===== rtl/ray_circle_entry_point.sv =====
`timescale 1ns / 1ps
// Entry point of a moving circle into a still circle, signed fixed point with
// COORD_WIDTH-bit coordinates. Each word gives both centres, both radii and the
// mover's velocity; the result is the point where the mover first touches the
// still circle (the root nearer the previous position), saturated, with a
// status on m_tuser: 0 hit, 1 miss (no real root), 2 zero velocity; on a miss
// or zero velocity the point is the mover position. The block takes one word
// per clock while the output is not stalled and keeps many in flight. The
// square root and the divider are bit-per-stage pipelines. A stalled output
// holds the whole pipeline.
module ray_circle_entry_point #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // still_x, still_y, still_radius, mover_x, mover_y, mover_radius, vel_x, vel_y
    input  logic [((8*COORD_WIDTH-2+7)/8)*8-1:0]    s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // impact_x, impact_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]      m_tdata,
    // status
    output logic [1:0]                              m_tuser
);

    localparam int W     = COORD_WIDTH;
    localparam int S_TW  = ((8*W-2+7)/8)*8;
    localparam int M_TW  = ((2*W+7)/8)*8;
    localparam int HW    = 2*W + 2;
    localparam int CW    = 2*W + 3;
    localparam int DSW   = 4*W + 4;
    localparam int WRAD  = 4*W + 3;
    localparam int SW    = (WRAD + 1) / 2;
    localparam int NUMW  = 2*W + 4;
    localparam int NMW   = 2*W + 3;
    localparam int PMW   = NMW + W;
    localparam int NNW   = PMW + 2;
    localparam int DW    = 2*W + 1;
    localparam int P1W   = 2*W + HW + 4*W;
    localparam int P2W   = 2 + 2*W + HW + 4*W;
    localparam int P3W   = 3 + 2*W + 2*W;
    localparam int P4W   = 4 + 2*W;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input fields
    logic signed [W-1:0] still_x, still_y, mover_x, mover_y, vel_x, vel_y;
    logic [W-2:0]        still_radius, mover_radius;

    assign still_x      = s_tdata[0 +: W];
    assign still_y      = s_tdata[W +: W];
    assign still_radius = s_tdata[2*W +: W-1];
    assign mover_x      = s_tdata[3*W-1 +: W];
    assign mover_y      = s_tdata[4*W-1 +: W];
    assign mover_radius = s_tdata[5*W-1 +: W-1];
    assign vel_x        = s_tdata[6*W-2 +: W];
    assign vel_y        = s_tdata[7*W-2 +: W];

    // stage 0: offsets and radius sum
    logic                vld0_reg;
    logic signed [W:0]   dx0_reg, dy0_reg;
    logic [W-1:0]        r0_reg;
    logic signed [W-1:0] mx0_reg, my0_reg, vx0_reg, vy0_reg;
    logic signed [W:0]   dx0_next, dy0_next;
    logic [W-1:0]        r0_next;

    assign dx0_next = (W+1)'(mover_x) - (W+1)'(still_x);
    assign dy0_next = (W+1)'(mover_y) - (W+1)'(still_y);
    assign r0_next  = W'(still_radius) + W'(mover_radius);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld0_reg <= 1'b0;
        end else if (en) begin
            vld0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx0_reg <= dx0_next;
            dy0_reg <= dy0_next;
            r0_reg  <= r0_next;
            mx0_reg <= mover_x;
            my0_reg <= mover_y;
            vx0_reg <= vel_x;
            vy0_reg <= vel_y;
        end
    end

    // stage 1: single products
    logic                 vld1_reg;
    logic signed [2*W:0]  hx1_reg, hy1_reg;
    logic [2*W-1:0]       dxx1_reg, dyy1_reg, vxx1_reg, vyy1_reg, rr1_reg;
    logic signed [W-1:0]  mx1_reg, my1_reg, vx1_reg, vy1_reg;
    logic signed [2*W:0]  hx1_next, hy1_next;
    logic signed [2*W+1:0] dxx_full, dyy_full, vxx_full, vyy_full;
    logic [2*W-1:0]       rr1_next;

    assign hx1_next = (2*W+1)'(dx0_reg) * (2*W+1)'(vx0_reg);
    assign hy1_next = (2*W+1)'(dy0_reg) * (2*W+1)'(vy0_reg);
    assign dxx_full = (2*W+2)'(dx0_reg) * (2*W+2)'(dx0_reg);
    assign dyy_full = (2*W+2)'(dy0_reg) * (2*W+2)'(dy0_reg);
    assign vxx_full = (2*W+2)'(vx0_reg) * (2*W+2)'(vx0_reg);
    assign vyy_full = (2*W+2)'(vy0_reg) * (2*W+2)'(vy0_reg);
    assign rr1_next = (2*W)'(r0_reg) * (2*W)'(r0_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= vld0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hx1_reg  <= hx1_next;
            hy1_reg  <= hy1_next;
            dxx1_reg <= dxx_full[2*W-1:0];
            dyy1_reg <= dyy_full[2*W-1:0];
            vxx1_reg <= vxx_full[2*W-1:0];
            vyy1_reg <= vyy_full[2*W-1:0];
            rr1_reg  <= rr1_next;
            mx1_reg  <= mx0_reg;
            my1_reg  <= my0_reg;
            vx1_reg  <= vx0_reg;
            vy1_reg  <= vy0_reg;
        end
    end

    // stage 2: A = v.v, h = d.v, C = d.d - r^2, with magnitudes
    logic                 vld2_reg;
    logic [2*W-1:0]       a2_reg;
    logic signed [HW-1:0] h2_reg;
    logic [2*W:0]         hmag2_reg;
    logic [2*W+1:0]       cmag2_reg;
    logic                 cneg2_reg;
    logic signed [W-1:0]  mx2_reg, my2_reg, vx2_reg, vy2_reg;
    logic [2*W-1:0]       a2_next;
    logic signed [HW-1:0] h2_next;
    logic signed [CW-1:0] c2_next;
    logic signed [HW-1:0] hneg2;
    logic signed [CW-1:0] cneg2;

    assign a2_next = vxx1_reg + vyy1_reg;
    assign h2_next = HW'(hx1_reg) + HW'(hy1_reg);
    assign c2_next = $signed({3'b000, dxx1_reg}) + $signed({3'b000, dyy1_reg})
                   - $signed({3'b000, rr1_reg});
    assign hneg2   = -h2_next;
    assign cneg2   = -c2_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a2_reg    <= a2_next;
            h2_reg    <= h2_next;
            hmag2_reg <= h2_next[HW-1] ? hneg2[2*W:0] : h2_next[2*W:0];
            cmag2_reg <= c2_next[CW-1] ? cneg2[2*W+1:0] : c2_next[2*W+1:0];
            cneg2_reg <= c2_next[CW-1];
            mx2_reg   <= mx1_reg;
            my2_reg   <= my1_reg;
            vx2_reg   <= vx1_reg;
            vy2_reg   <= vy1_reg;
        end
    end

    // h^2 and A*|C|
    logic                 vld_hh, vld_ac;
    logic [4*W+2:0]       hh_p;
    logic [4*W+1:0]       ac_p;
    logic [P1W-1:0]       pay1_out;
    logic                 cneg_m1;
    logic [2*W-1:0]       a_m1;
    logic signed [HW-1:0] h_m1;
    logic signed [W-1:0]  mx_m1, my_m1, vx_m1, vy_m1;

    rcep_mul #(.WA(2*W+1), .WB(2*W+2), .PW(P1W)) u_mul_hh (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (vld2_reg),
        .a       (hmag2_reg),
        .b       ((2*W+2)'(hmag2_reg)),
        .pay_in  ({a2_reg, h2_reg, mx2_reg, my2_reg, vx2_reg, vy2_reg}),
        .vld_out (vld_hh),
        .prod    (hh_p),
        .pay_out (pay1_out)
    );

    rcep_mul #(.WA(2*W), .WB(2*W+2), .PW(1)) u_mul_ac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (vld2_reg),
        .a       (a2_reg),
        .b       (cmag2_reg),
        .pay_in  (cneg2_reg),
        .vld_out (vld_ac),
        .prod    (ac_p),
        .pay_out (cneg_m1)
    );

    assign {a_m1, h_m1, mx_m1, my_m1, vx_m1, vy_m1} = pay1_out;

    // stage 3: discriminant and status
    logic                  vld3_reg;
    logic [WRAD-1:0]       rad3_reg;
    rcep_pkg::status_t     st3_reg;
    logic [2*W-1:0]        a3_reg;
    logic signed [HW-1:0]  h3_reg;
    logic signed [W-1:0]   mx3_reg, my3_reg, vx3_reg, vy3_reg;
    logic signed [DSW-1:0] disc_next;
    rcep_pkg::status_t     st3_next;

    assign disc_next = cneg_m1 ? $signed({1'b0, hh_p}) + $signed({2'b00, ac_p})
                               : $signed({1'b0, hh_p}) - $signed({2'b00, ac_p});

    always_comb begin
        if (a_m1 == '0) begin
            st3_next = rcep_pkg::STATUS_ZERO_VEL;
        end else if (disc_next[DSW-1]) begin
            st3_next = rcep_pkg::STATUS_MISS;
        end else begin
            st3_next = rcep_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (en) begin
            vld3_reg <= vld_hh && vld_ac;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad3_reg <= disc_next[WRAD-1:0];
            st3_reg  <= st3_next;
            a3_reg   <= a_m1;
            h3_reg   <= h_m1;
            mx3_reg  <= mx_m1;
            my3_reg  <= my_m1;
            vx3_reg  <= vx_m1;
            vy3_reg  <= vy_m1;
        end
    end

    // floor square root of the discriminant
    logic                 vld_sq;
    logic [SW-1:0]        s_sq;
    logic [P2W-1:0]       pay2_out;
    rcep_pkg::status_t    st_sq;
    logic [2*W-1:0]       a_sq;
    logic signed [HW-1:0] h_sq;
    logic signed [W-1:0]  mx_sq, my_sq, vx_sq, vy_sq;

    rcep_sqrt #(.WR(WRAD), .PW(P2W)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (vld3_reg),
        .rad     (rad3_reg),
        .pay_in  ({st3_reg, a3_reg, h3_reg, mx3_reg, my3_reg, vx3_reg, vy3_reg}),
        .vld_out (vld_sq),
        .root    (s_sq),
        .pay_out (pay2_out)
    );

    assign {st_sq, a_sq, h_sq, mx_sq, my_sq, vx_sq, vy_sq} = pay2_out;

    // stage 4: root choice and signed magnitudes
    logic                   vld4_reg;
    logic [NMW-1:0]         nmag4_reg;
    logic [W-1:0]           vxm4_reg, vym4_reg;
    logic                   negx4_reg, negy4_reg;
    rcep_pkg::status_t      st4_reg;
    logic [2*W-1:0]         a4_reg;
    logic signed [W-1:0]    mx4_reg, my4_reg;
    logic signed [NUMW-1:0] s_e, h_e, num_next, numn;
    logic                   take_plus;
    logic [W-1:0]           vxn, vyn;

    assign s_e       = $signed({2'b00, s_sq});
    assign h_e       = NUMW'(h_sq);
    assign take_plus = (h_sq > $signed({2'b00, a_sq}));
    assign num_next  = take_plus ? s_e - h_e : -h_e - s_e;
    assign numn      = -num_next;
    assign vxn       = -vx_sq;
    assign vyn       = -vy_sq;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
        end else if (en) begin
            vld4_reg <= vld_sq;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nmag4_reg <= num_next[NUMW-1] ? numn[NMW-1:0] : num_next[NMW-1:0];
            vxm4_reg  <= vx_sq[W-1] ? vxn : vx_sq;
            vym4_reg  <= vy_sq[W-1] ? vyn : vy_sq;
            negx4_reg <= num_next[NUMW-1] ^ vx_sq[W-1];
            negy4_reg <= num_next[NUMW-1] ^ vy_sq[W-1];
            st4_reg   <= st_sq;
            a4_reg    <= a_sq;
            mx4_reg   <= mx_sq;
            my4_reg   <= my_sq;
        end
    end

    // |v * num| for both axes
    logic                vld_px, vld_py;
    logic [PMW-1:0]      pmx, pmy;
    logic [P3W-1:0]      pay3_out;
    logic                negx_m2, negy_m2;
    rcep_pkg::status_t   st_m2;
    logic [2*W-1:0]      a_m2;
    logic signed [W-1:0] mx_m2, my_m2;

    rcep_mul #(.WA(NMW), .WB(W), .PW(P3W)) u_mul_px (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (vld4_reg),
        .a       (nmag4_reg),
        .b       (vxm4_reg),
        .pay_in  ({negx4_reg, st4_reg, a4_reg, mx4_reg, my4_reg}),
        .vld_out (vld_px),
        .prod    (pmx),
        .pay_out (pay3_out)
    );

    rcep_mul #(.WA(NMW), .WB(W), .PW(1)) u_mul_py (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (vld4_reg),
        .a       (nmag4_reg),
        .b       (vym4_reg),
        .pay_in  (negy4_reg),
        .vld_out (vld_py),
        .prod    (pmy),
        .pay_out (negy_m2)
    );

    assign {negx_m2, st_m2, a_m2, mx_m2, my_m2} = pay3_out;

    // stage 5: rounding numerators 2|p| + A over 2A, quotient overflow check
    logic                vld5_reg;
    logic [NNW-1:0]      nx5_reg, ny5_reg;
    logic [DW-1:0]       d5_reg;
    logic                ovfx5_reg, ovfy5_reg, negx5_reg, negy5_reg;
    rcep_pkg::status_t   st5_reg;
    logic signed [W-1:0] mx5_reg, my5_reg;
    logic [NNW-1:0]      nx_next, ny_next, dlim;
    logic [DW-1:0]       d_next;

    assign nx_next = NNW'({pmx, 1'b0}) + NNW'(a_m2);
    assign ny_next = NNW'({pmy, 1'b0}) + NNW'(a_m2);
    assign d_next  = {a_m2, 1'b0};
    assign dlim    = NNW'(d_next) << W;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld5_reg <= 1'b0;
        end else if (en) begin
            vld5_reg <= vld_px && vld_py;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx5_reg   <= nx_next;
            ny5_reg   <= ny_next;
            d5_reg    <= d_next;
            ovfx5_reg <= (nx_next >= dlim);
            ovfy5_reg <= (ny_next >= dlim);
            negx5_reg <= negx_m2;
            negy5_reg <= negy_m2;
            st5_reg   <= st_m2;
            mx5_reg   <= mx_m2;
            my5_reg   <= my_m2;
        end
    end

    // rounded offsets
    logic                vld_qx, vld_qy;
    logic [W-1:0]        qdx, qdy;
    logic [P4W-1:0]      pay4_out;
    logic                ovfx_d, negx_d, ovfy_d, negy_d;
    rcep_pkg::status_t   st_d;
    logic signed [W-1:0] mx_d, my_d;

    rcep_div #(.WN(NNW), .WD(DW), .NQ(W), .PW(P4W)) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (vld5_reg),
        .num     (nx5_reg),
        .den     (d5_reg),
        .pay_in  ({ovfx5_reg, negx5_reg, st5_reg, mx5_reg, my5_reg}),
        .vld_out (vld_qx),
        .quo     (qdx),
        .pay_out (pay4_out)
    );

    rcep_div #(.WN(NNW), .WD(DW), .NQ(W), .PW(2)) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (vld5_reg),
        .num     (ny5_reg),
        .den     (d5_reg),
        .pay_in  ({ovfy5_reg, negy5_reg}),
        .vld_out (vld_qy),
        .quo     (qdy),
        .pay_out ({ovfy_d, negy_d})
    );

    assign {ovfx_d, negx_d, st_d, mx_d, my_d} = pay4_out;

    // final: add offset, saturate, select by status
    function automatic logic [W-1:0] sat_w(input logic signed [W+1:0] v);
        logic [W-1:0] r;
        if (v[W+1:W-1] == '0 || v[W+1:W-1] == '1) begin
            r = v[W-1:0];
        end else if (v[W+1]) begin
            r = {1'b1, {(W-1){1'b0}}};
        end else begin
            r = {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    logic [W:0]          qx, qy;
    logic signed [W+1:0] qx_e, qy_e, mx_e, my_e, sumx, sumy;
    logic [W-1:0]        ix_next, iy_next;

    assign qx   = ovfx_d ? {1'b1, {W{1'b0}}} : {1'b0, qdx};
    assign qy   = ovfy_d ? {1'b1, {W{1'b0}}} : {1'b0, qdy};
    assign qx_e = $signed({1'b0, qx});
    assign qy_e = $signed({1'b0, qy});
    assign mx_e = (W+2)'(mx_d);
    assign my_e = (W+2)'(my_d);
    assign sumx = negx_d ? mx_e - qx_e : mx_e + qx_e;
    assign sumy = negy_d ? my_e - qy_e : my_e + qy_e;

    always_comb begin
        case (st_d)
            rcep_pkg::STATUS_OK: begin
                ix_next = sat_w(sumx);
                iy_next = sat_w(sumy);
            end
            default: begin
                ix_next = mx_d;
                iy_next = my_d;
            end
        endcase
    end

    logic              m_tvalid_reg;
    logic [M_TW-1:0]   m_tdata_reg;
    rcep_pkg::status_t m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_qx && vld_qy;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= M_TW'({iy_next, ix_next});
            m_tuser_reg <= st_d;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/rcep_mul.sv =====
`timescale 1ns / 1ps
module rcep_mul #(
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int PW = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              vld_in,
    input  logic [WA-1:0]     a,
    input  logic [WB-1:0]     b,
    input  logic [PW-1:0]     pay_in,
    output logic              vld_out,
    output logic [WA+WB-1:0]  prod,
    output logic [PW-1:0]     pay_out
);

    localparam int DB  = rcep_pkg::DIGIT_BITS;
    localparam int ND  = (WB + DB - 1) / DB;
    localparam int WBP = ND * DB;
    localparam int WP  = WA + WB;

    logic [WP-1:0]  acc_reg [ND];
    logic [WA-1:0]  a_reg   [ND];
    logic [WBP-1:0] b_reg   [ND];
    logic [PW-1:0]  pay_reg [ND];
    logic           vld_reg [ND];

    genvar k;
    generate
        for (k = 0; k < ND; k++) begin : g_stage
            logic [WP-1:0]  acc_in;
            logic [WA-1:0]  a_in;
            logic [WBP-1:0] b_in;
            logic [PW-1:0]  pay_s;
            logic           vld_s;
            logic [WP-1:0]  a_wide;
            logic [DB-1:0]  digit;
            logic [WP-1:0]  acc_next;

            if (k == 0) begin : g_first
                assign acc_in = '0;
                assign a_in   = a;
                assign b_in   = WBP'(b);
                assign pay_s  = pay_in;
                assign vld_s  = vld_in;
            end else begin : g_rest
                assign acc_in = acc_reg[k-1];
                assign a_in   = a_reg[k-1];
                assign b_in   = b_reg[k-1];
                assign pay_s  = pay_reg[k-1];
                assign vld_s  = vld_reg[k-1];
            end

            // add one partial product per stage
            assign a_wide   = WP'(a_in);
            assign digit    = b_in[k*DB +: DB];
            assign acc_next = acc_in + ((a_wide * WP'(digit)) << (k * DB));

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_s;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    acc_reg[k] <= acc_next;
                    a_reg[k]   <= a_in;
                    b_reg[k]   <= b_in;
                    pay_reg[k] <= pay_s;
                end
            end
        end
    endgenerate

    assign vld_out = vld_reg[ND-1];
    assign prod    = acc_reg[ND-1];
    assign pay_out = pay_reg[ND-1];

endmodule

// ===== rtl/rcep_sqrt.sv =====
`timescale 1ns / 1ps
module rcep_sqrt #(
    parameter int WR = 64,
    parameter int PW = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 vld_in,
    input  logic [WR-1:0]        rad,
    input  logic [PW-1:0]        pay_in,
    output logic                 vld_out,
    output logic [(WR+1)/2-1:0]  root,
    output logic [PW-1:0]        pay_out
);

    localparam int NR = (WR + 1) / 2;
    localparam int RW = NR + 2;

    logic [2*NR-1:0] rad_reg  [NR];
    logic [RW-1:0]   rem_reg  [NR];
    logic [NR-1:0]   root_reg [NR];
    logic [PW-1:0]   pay_reg  [NR];
    logic            vld_reg  [NR];

    genvar k;
    generate
        for (k = 0; k < NR; k++) begin : g_stage
            logic [2*NR-1:0] rad_in;
            logic [RW-1:0]   rem_in;
            logic [NR-1:0]   root_in;
            logic [PW-1:0]   pay_s;
            logic            vld_s;
            logic [RW+1:0]   cur;
            logic [RW+1:0]   trial;
            logic            ge;
            logic [RW-1:0]   rem_next;
            logic [NR-1:0]   root_next;

            if (k == 0) begin : g_first
                assign rad_in  = (2*NR)'(rad);
                assign rem_in  = '0;
                assign root_in = '0;
                assign pay_s   = pay_in;
                assign vld_s   = vld_in;
            end else begin : g_rest
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign pay_s   = pay_reg[k-1];
                assign vld_s   = vld_reg[k-1];
            end

            // bring down two radicand bits, try root*4+1
            assign cur       = {rem_in, rad_in[2*(NR-1-k) +: 2]};
            assign trial     = (RW+2)'({root_in, 2'b01});
            assign ge        = (cur >= trial);
            assign rem_next  = ge ? RW'(cur - trial) : RW'(cur);
            assign root_next = {root_in[NR-2:0], ge};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_s;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k]  <= rad_in;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                    pay_reg[k]  <= pay_s;
                end
            end
        end
    endgenerate

    assign vld_out = vld_reg[NR-1];
    assign root    = root_reg[NR-1];
    assign pay_out = pay_reg[NR-1];

endmodule

// ===== rtl/rcep_div.sv =====
`timescale 1ns / 1ps
module rcep_div #(
    parameter int WN = 64,
    parameter int WD = 32,
    parameter int NQ = 32,
    parameter int PW = 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           vld_in,
    input  logic [WN-1:0]  num,
    input  logic [WD-1:0]  den,
    input  logic [PW-1:0]  pay_in,
    output logic           vld_out,
    output logic [NQ-1:0]  quo,
    output logic [PW-1:0]  pay_out
);

    logic [WN-1:0] rem_reg [NQ];
    logic [WD-1:0] den_reg [NQ];
    logic [NQ-1:0] quo_reg [NQ];
    logic [PW-1:0] pay_reg [NQ];
    logic          vld_reg [NQ];

    genvar k;
    generate
        for (k = 0; k < NQ; k++) begin : g_stage
            logic [WN-1:0] rem_in;
            logic [WD-1:0] den_in;
            logic [NQ-1:0] quo_in;
            logic [PW-1:0] pay_s;
            logic          vld_s;
            logic [WN-1:0] dsh;
            logic          ge;
            logic [WN-1:0] rem_next;
            logic [NQ-1:0] quo_next;

            if (k == 0) begin : g_first
                assign rem_in = num;
                assign den_in = den;
                assign quo_in = '0;
                assign pay_s  = pay_in;
                assign vld_s  = vld_in;
            end else begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign den_in = den_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign pay_s  = pay_reg[k-1];
                assign vld_s  = vld_reg[k-1];
            end

            // one quotient bit per stage, most significant first
            assign dsh      = WN'(den_in) << (NQ - 1 - k);
            assign ge       = (rem_in >= dsh);
            assign rem_next = ge ? rem_in - dsh : rem_in;
            assign quo_next = {quo_in[NQ-2:0], ge};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_s;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                    quo_reg[k] <= quo_next;
                    pay_reg[k] <= pay_s;
                end
            end
        end
    endgenerate

    assign vld_out = vld_reg[NQ-1];
    assign quo     = quo_reg[NQ-1];
    assign pay_out = pay_reg[NQ-1];

endmodule

// ===== rtl/rcep_checker.sv =====
`timescale 1ns / 1ps
`include "ray_circle_entry_point_assert.svh"
module rcep_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((2*COORD_WIDTH+7)/8)*8-1:0]   m_tdata,
    input logic [1:0]                           m_tuser
);

    logic status_known;
    assign status_known = (m_tuser == rcep_pkg::STATUS_OK)
                       || (m_tuser == rcep_pkg::STATUS_MISS)
                       || (m_tuser == rcep_pkg::STATUS_ZERO_VEL);

    // a free output stage never blocks the input
    `RCEP_ASSERT_NOW(a_ready_when_free, aclk, aresetn, !m_tvalid || m_tready, s_tready)

    // status is one of the defined codes
    `RCEP_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, status_known)

    // hold a stalled word
    `RCEP_ASSERT_NEXT(a_valid_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    `RCEP_ASSERT_NEXT(a_data_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    `RCEP_ASSERT_NEXT(a_user_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tuser))

endmodule

bind ray_circle_entry_point rcep_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rcep_checker (.*);

// ===== test/ray_circle_entry_point_tb.sv =====
`timescale 1ns / 1ps
module ray_circle_entry_point_tb;

    localparam int CW       = 32;
    localparam int IN_BITS  = ((8*CW-2+7)/8)*8;
    localparam int OUT_BITS = ((2*CW+7)/8)*8;
    localparam int LATENCY  = 112;
    localparam int N_RANDOM = 1750;
    localparam longint CYCLE_LIMIT = 400000;

    localparam logic signed [31:0] SMAX = 32'sh7fffffff;
    localparam logic signed [31:0] SMIN = 32'sh80000000;
    localparam logic [30:0]        RMAX = 31'h7fffffff;

    typedef struct packed {
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic [30:0]        mover_radius;
        logic signed [31:0] mover_y;
        logic signed [31:0] mover_x;
        logic [30:0]        still_radius;
        logic signed [31:0] still_y;
        logic signed [31:0] still_x;
    } query_t;

    typedef struct packed {
        logic signed [31:0] impact_y;
        logic signed [31:0] impact_x;
        rcep_pkg::status_t  status;
    } impact_t;

    typedef struct {
        query_t  q;
        bit      typed;
        impact_t want;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_BITS-1:0] m_tdata;
    logic [1:0]          m_tuser;

    ray_circle_entry_point #(.COORD_WIDTH(CW)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    impact_t pending_impacts[$];
    int      n_errors = 0;
    int      n_results = 0;
    int      n_hit = 0, n_miss = 0, n_still = 0;
    longint  cycles = 0;
    bit      hold_off = 1'b0;

    function automatic void queue_impact(impact_t r);
        pending_impacts.insert(pending_impacts.size(), r);
    endfunction

    // exact entry point; 256-bit signed arithmetic covers all products
    function automatic logic signed [31:0] sat32(logic signed [255:0] v);
        if (v > 256'(SMAX)) return SMAX;
        if (v < 256'(signed'(SMIN))) return SMIN;
        return v[31:0];
    endfunction

    function automatic logic signed [255:0] isqrt(logic signed [255:0] x);
        logic [255:0] res, bitv, t;
        res = '0;
        bitv = 256'b1 << 254;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            t = res + bitv;
            if (x >= t) begin
                x = x - t;
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // round(vel*num/a), ties away from zero
    function automatic logic signed [255:0] step_offset(logic signed [255:0] vel,
            logic signed [255:0] num, logic signed [255:0] a);
        logic signed [255:0] p, mag, quo;
        p = vel * num;
        mag = p < 0 ? -p : p;
        quo = (2 * mag + a) / (2 * a);
        return p < 0 ? -quo : quo;
    endfunction

    function automatic impact_t entry_point(query_t q);
        logic signed [255:0] dx, dy, vx, vy, rr, a, h, c, disc, s, num;
        impact_t r;
        vx = 256'(q.vel_x);
        vy = 256'(q.vel_y);
        dx = 256'(q.mover_x) - 256'(q.still_x);
        dy = 256'(q.mover_y) - 256'(q.still_y);
        rr = 256'({1'b0, q.still_radius}) + 256'({1'b0, q.mover_radius});
        a = vx * vx + vy * vy;
        h = dx * vx + dy * vy;
        c = dx * dx + dy * dy - rr * rr;
        disc = h * h - a * c;
        r.impact_x = q.mover_x;
        r.impact_y = q.mover_y;
        if (a == 0) begin
            r.status = rcep_pkg::STATUS_ZERO_VEL;
        end else if (disc < 0) begin
            r.status = rcep_pkg::STATUS_MISS;
        end else begin
            s = isqrt(disc);
            num = (h > a) ? s - h : -h - s;
            r.impact_x = sat32(256'(q.mover_x) + step_offset(vx, num, a));
            r.impact_y = sat32(256'(q.mover_y) + step_offset(vy, num, a));
            r.status = rcep_pkg::STATUS_OK;
        end
        return r;
    endfunction

    function automatic query_t rand_query(int mode);
        query_t q;
        int sh;
        q = ($bits(query_t))'({$urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom});
        if (mode < 7) begin
            // well-formed: moderate scene, mover aimed near the still circle
            sh = $urandom_range(8, 24);
            q.still_x = $signed($urandom) >>> sh;
            q.still_y = $signed($urandom) >>> sh;
            q.mover_x = $signed($urandom) >>> sh;
            q.mover_y = $signed($urandom) >>> sh;
            q.still_radius = 31'($urandom >> (sh + 1));
            q.mover_radius = 31'($urandom >> (sh + 1));
            q.vel_x = (q.still_x - q.mover_x) + ($signed($urandom) >>> (sh + 2));
            q.vel_y = (q.still_y - q.mover_y) + ($signed($urandom) >>> (sh + 2));
            if ($urandom_range(0, 3) == 0) q.vel_x = -q.vel_x;
        end else if (mode == 7) begin
            q.vel_x = '0;
            q.vel_y = '0;
        end
        return q;
    endfunction

    task automatic send(query_t q);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_BITS'(q);
        queue_impact(entry_point(q));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic maybe_gap();
        if ($urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // receiver: random stall pattern plus the long hold-off
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (!aresetn || hold_off) m_tready <= 1'b0;
        else if ((cycles / 300) % 3 == 0) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("ray_circle_entry_point_tb failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        impact_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.impact_x = m_tdata[31:0];
            got.impact_y = m_tdata[63:32];
            got.status   = m_tuser;
            n_results++;
            if (pending_impacts.size() == 0) begin
                $display("%0t: unexpected result %h/%h/%0d", $time,
                         got.impact_x, got.impact_y, got.status);
                n_errors++;
            end else begin
                want = pending_impacts.pop_front();
                case (want.status)
                    rcep_pkg::STATUS_OK:   n_hit++;
                    rcep_pkg::STATUS_MISS: n_miss++;
                    default:               n_still++;
                endcase
                if (got.impact_x !== want.impact_x) begin
                    $display("%0t: impact_x expected %h actual %h", $time,
                             want.impact_x, got.impact_x);
                    n_errors++;
                end
                if (got.impact_y !== want.impact_y) begin
                    $display("%0t: impact_y expected %h actual %h", $time,
                             want.impact_y, got.impact_y);
                    n_errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, got.status);
                    n_errors++;
                end
            end
        end
    end

    function automatic row_t mk(logic signed [31:0] sx, logic signed [31:0] sy,
            logic [30:0] sr, logic signed [31:0] mx, logic signed [31:0] my,
            logic [30:0] mr, logic signed [31:0] vx, logic signed [31:0] vy,
            bit typed, logic signed [31:0] ix, logic signed [31:0] iy,
            rcep_pkg::status_t st);
        row_t r;
        r.q = '{still_x: sx, still_y: sy, still_radius: sr, mover_x: mx, mover_y: my,
                mover_radius: mr, vel_x: vx, vel_y: vy};
        r.typed = typed;
        r.want = '{impact_x: ix, impact_y: iy, status: st};
        return r;
    endfunction

    row_t directed[$];

    function automatic void add_row(row_t r);
        directed.insert(directed.size(), r);
    endfunction

    initial begin
        int n_sent;
        int k;
        impact_t calc;
        // zero velocity, mover position comes back
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, rcep_pkg::STATUS_ZERO_VEL));
        add_row(mk(SMIN, SMAX, RMAX, SMAX, SMIN, RMAX, 0, 0,
                   1, SMAX, SMIN, rcep_pkg::STATUS_ZERO_VEL));
        add_row(mk(SMAX, SMIN, 0, SMIN, SMAX, 0, 0, 0,
                   1, SMIN, SMAX, rcep_pkg::STATUS_ZERO_VEL));
        // clear miss: moving parallel, far off
        add_row(mk(0, 0, 31'h10000, 0, 32'h1000000, 31'h10000, 32'h10000, 0,
                   1, 0, 32'h1000000, rcep_pkg::STATUS_MISS));
        // head-on hit along x: touches at x = -2.0
        add_row(mk(0, 0, 31'h10000, -32'sh40000, 0, 31'h10000, 32'h10000, 0,
                   1, -32'sh20000, 0, rcep_pkg::STATUS_OK));
        // tangent, equal roots
        add_row(mk(0, 0, 31'h10000, -32'sh40000, 32'h20000, 31'h10000,
                   32'h10000, 0, 0, 0, 0, rcep_pkg::STATUS_OK));
        // mover already inside, both root branches
        add_row(mk(0, 0, 31'h100000, 32'h10, 0, 0, 32'h10000, 0,
                   0, 0, 0, rcep_pkg::STATUS_OK));
        add_row(mk(0, 0, 31'h100, 32'h10, 0, 0, 32'h4, 32'h3,
                   0, 0, 0, rcep_pkg::STATUS_OK));
        add_row(mk(0, 0, 31'h100, -32'sh10, 0, 0, -32'sh7, 32'h1,
                   0, 0, 0, rcep_pkg::STATUS_OK));
        // extremes: saturating results and large products
        add_row(mk(SMIN, SMIN, RMAX, SMAX, SMAX, RMAX, SMIN, SMIN,
                   0, 0, 0, rcep_pkg::STATUS_OK));
        add_row(mk(SMAX, SMAX, RMAX, SMIN, SMIN, RMAX, SMAX, SMAX,
                   0, 0, 0, rcep_pkg::STATUS_OK));
        add_row(mk(SMAX, SMIN, RMAX, SMIN, SMAX, 0, SMAX, SMIN,
                   0, 0, 0, rcep_pkg::STATUS_OK));
        add_row(mk(0, 0, RMAX, SMAX, 0, RMAX, 1, 0, 0, 0, 0, rcep_pkg::STATUS_OK));
        add_row(mk(0, 0, 0, SMAX, SMAX, 0, -1, -1, 0, 0, 0, rcep_pkg::STATUS_OK));
        add_row(mk(-1, -1, 1, 1, 1, 1, SMIN, 1, 0, 0, 0, rcep_pkg::STATUS_OK));
        add_row(mk(5, -3, 2, -9, 4, 1, 3, -1, 0, 0, 0, rcep_pkg::STATUS_OK));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            calc = entry_point(directed[i].q);
            if (directed[i].typed && calc !== directed[i].want) begin
                $display("%0t: row %0d expected %h actual %h", $time, i,
                         directed[i].want, calc);
                n_errors++;
            end
            send(directed[i].q);
            maybe_gap();
        end

        n_sent = 0;
        while (n_sent < N_RANDOM) begin
            k = $urandom_range(1, 40);
            repeat (k) begin
                send(rand_query($urandom_range(0, 9)));
                n_sent++;
                if (n_sent == 600) begin
                    // starve the output so the pipeline backs up into s_tready
                    hold_off = 1'b1;
                    fork
                        begin
                            repeat (400) @(posedge aclk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
            end
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge aclk);
            else @(posedge aclk);
        end
        s_tvalid <= 1'b0;

        while (pending_impacts.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);

        $display("%0d queries checked: %0d hits, %0d misses, %0d zero-velocity",
                 n_results, n_hit, n_miss, n_still);
        $display("directed extremes, random scenes, bursty input and output stalls");
        if (n_errors == 0) begin
            $display("ray_circle_entry_point_tb passed");
        end else begin
            $display("ray_circle_entry_point_tb failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rcep_pkg.sv
rtl/rcep_mul.sv
rtl/rcep_sqrt.sv
rtl/rcep_div.sv
rtl/ray_circle_entry_point.sv
rtl/rcep_checker.sv
test/ray_circle_entry_point_tb.sv
